// ----- sv/aatf_pkg.sv -----
// Package with the shared types and constants of the box transform core.
package aatf_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned ROW_W   = 3 * COEF_W;
  localparam int unsigned PROD_W  = COEF_W + COORD_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned FRAC_SH = 12;
  localparam int unsigned RES_W   = SUM_W - FRAC_SH + 1;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] q16_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [RES_W-1:0]   res_t;

  typedef q16_t [2:0] coord_t;
  typedef row_t [2:0] rows_t;
  typedef sum_t [2:0] sums_t;

  // Both candidate products of one coefficient: against the lower and the upper bound.
  typedef struct packed {
    prod_t lo;
    prod_t hi;
  } pair_t;

  typedef pair_t [2:0][2:0] pair_grid_t;
  typedef prod_t [2:0][2:0] prod_grid_t;

  typedef struct packed {
    q16_t [2:0] mn;
    q16_t [2:0] mx;
    logic       sat;
  } box_res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_t;

  localparam row_t ROW_X_RESET = ROW_W'(48'h0000_0000_1000);
  localparam row_t ROW_Y_RESET = ROW_W'(48'h0000_1000_0000);
  localparam row_t ROW_Z_RESET = ROW_W'(48'h1000_0000_0000);

  localparam res_t Q16_MAX = res_t'(64'sd2147483647);
  localparam res_t Q16_MIN = res_t'(-64'sd2147483648);

endpackage

// ----- sv/aatf_if.sv -----
// Handshake interfaces for the box input channel and the result channel.
interface aatf_box_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] min_z;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;
  logic signed [31:0] max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface aatf_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_min_x;
  logic signed [31:0] out_min_y;
  logic signed [31:0] out_min_z;
  logic signed [31:0] out_max_x;
  logic signed [31:0] out_max_y;
  logic signed [31:0] out_max_z;
  logic               saturated;

  modport source (output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y,
                  out_max_z, saturated, input ready);
  modport sink   (input valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y,
                  out_max_z, saturated, output ready);
endinterface

// ----- sv/aabb_affine_transform_core.sv -----
// Top level of the axis-aligned bounding box affine transform core.
// This core takes one axis-aligned box per beat on in_box, as six signed Q16.16 bounds, and
// returns on out_box the box that encloses its eight corners after the configured affine
// transform: a 3x3 linear part of signed Q4.12 coefficients and a Q16.16 translation. Each
// corner coordinate is the exact sum of three products, shifted right by 12 with rounding
// toward minus infinity, plus the translation, and clamped to the signed 32-bit range; the
// saturated bit reports that an output minimum was raised or an output maximum was lowered
// by the clamp. Inverted bounds are not reordered, and the outputs are still the true extremes
// over the corners as given. The datapath is a four-stage pipeline (the multipliers, the
// per-term selection, the sums, and the scaling, translation and clamp into the output
// register), so a box is accepted in every cycle when out_box is not stalled; the eighteen
// 16 by 32 bit multipliers sit in the first stage. Back-pressure on out_box stalls the stages
// one by one, so bubbles close up and no beat is dropped or repeated. The matrix and the
// translation are written through the cfg_ port (index 0 to 2 the rows producing x, y and z,
// index 3 to 5 the translations; other indices are ignored) and must only change while no box
// is in flight. Reset loads the identity matrix and a zero translation.
module aabb_affine_transform_core (
  input  logic                        clk,
  input  logic                        rst_n,
  aatf_box_if.sink                    in_box,
  aatf_res_if.source                  out_box,
  input  logic                        cfg_we,
  input  logic [aatf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aatf_pkg::ROW_W-1:0]  cfg_wdata
);
  import aatf_pkg::*;

  rows_t      rows_r;
  coord_t     shift_r;
  coord_t     box_lo;
  coord_t     box_hi;

  logic       mul_valid;
  logic       mul_ready;
  pair_grid_t prod;
  logic       span_valid;
  logic       span_ready;
  sums_t      pmin;
  sums_t      pmax;
  box_res_t   res;

  // Configuration registers: plain writes, decoded by register index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0]  <= ROW_X_RESET;
      rows_r[1]  <= ROW_Y_RESET;
      rows_r[2]  <= ROW_Z_RESET;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X:   rows_r[0]  <= cfg_wdata;
        REG_ROW_Y:   rows_r[1]  <= cfg_wdata;
        REG_ROW_Z:   rows_r[2]  <= cfg_wdata;
        REG_SHIFT_X: shift_r[0] <= cfg_wdata[COORD_W-1:0];
        REG_SHIFT_Y: shift_r[1] <= cfg_wdata[COORD_W-1:0];
        REG_SHIFT_Z: shift_r[2] <= cfg_wdata[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign box_lo = {in_box.min_z, in_box.min_y, in_box.min_x};
  assign box_hi = {in_box.max_z, in_box.max_y, in_box.max_x};

  aatf_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_box.valid),
    .up_ready (in_box.ready),
    .lo       (box_lo),
    .hi       (box_hi),
    .rows     (rows_r),
    .dn_valid (mul_valid),
    .dn_ready (mul_ready),
    .prod     (prod)
  );

  aatf_span u_span (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mul_valid),
    .up_ready (mul_ready),
    .prod     (prod),
    .dn_valid (span_valid),
    .dn_ready (span_ready),
    .pmin     (pmin),
    .pmax     (pmax)
  );

  aatf_sat u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (span_valid),
    .up_ready (span_ready),
    .pmin     (pmin),
    .pmax     (pmax),
    .shift    (shift_r),
    .dn_valid (out_box.valid),
    .dn_ready (out_box.ready),
    .res      (res)
  );

  assign out_box.out_min_x = res.mn[0];
  assign out_box.out_min_y = res.mn[1];
  assign out_box.out_min_z = res.mn[2];
  assign out_box.out_max_x = res.mx[0];
  assign out_box.out_max_y = res.mx[1];
  assign out_box.out_max_z = res.mx[2];
  assign out_box.saturated = res.sat;

endmodule

// ----- sv/aatf_mul.sv -----
// Multiplier stage: every coefficient times the lower and the upper bound of its axis.
module aatf_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  aatf_pkg::coord_t    lo,
  input  aatf_pkg::coord_t    hi,
  input  aatf_pkg::rows_t     rows,
  output logic                dn_valid,
  input  logic                dn_ready,
  output aatf_pkg::pair_grid_t prod
);
  import aatf_pkg::*;

  logic       valid_r;
  pair_grid_t prod_r;
  pair_grid_t prod_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign prod     = prod_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[a][j].lo = $signed(rows[a][COEF_W*j +: COEF_W]) * $signed(lo[j]);
        prod_nxt[a][j].hi = $signed(rows[a][COEF_W*j +: COEF_W]) * $signed(hi[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- sv/aatf_span.sv -----
// Extent stages: per-term minimum and maximum, then the sums that bound each axis.
module aatf_span (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  aatf_pkg::pair_grid_t prod,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output aatf_pkg::sums_t      pmin,
  output aatf_pkg::sums_t      pmax
);
  import aatf_pkg::*;

  logic       sel_valid_r;
  logic       sum_valid_r;
  logic       sel_ready;
  logic       sum_ready;
  prod_grid_t tmin_r;
  prod_grid_t tmax_r;
  prod_grid_t tmin_nxt;
  prod_grid_t tmax_nxt;
  sums_t      pmin_r;
  sums_t      pmax_r;
  sums_t      pmin_nxt;
  sums_t      pmax_nxt;

  assign sum_ready = !sum_valid_r || dn_ready;
  assign sel_ready = !sel_valid_r || sum_ready;
  assign up_ready  = sel_ready;
  assign dn_valid  = sum_valid_r;
  assign pmin      = pmin_r;
  assign pmax      = pmax_r;

  // Each term depends on one coordinate only, so the corner extremes are sums of term extremes.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        if ($signed(prod[a][j].lo) < $signed(prod[a][j].hi)) begin
          tmin_nxt[a][j] = prod[a][j].lo;
          tmax_nxt[a][j] = prod[a][j].hi;
        end else begin
          tmin_nxt[a][j] = prod[a][j].hi;
          tmax_nxt[a][j] = prod[a][j].lo;
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pmin_nxt[a] = SUM_W'($signed(tmin_r[a][0])) + SUM_W'($signed(tmin_r[a][1]))
                  + SUM_W'($signed(tmin_r[a][2]));
      pmax_nxt[a] = SUM_W'($signed(tmax_r[a][0])) + SUM_W'($signed(tmax_r[a][1]))
                  + SUM_W'($signed(tmax_r[a][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
      sum_valid_r <= 1'b0;
    end else begin
      if (sel_ready) begin
        sel_valid_r <= up_valid;
      end
      if (sum_ready) begin
        sum_valid_r <= sel_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel_ready && up_valid) begin
      tmin_r <= tmin_nxt;
      tmax_r <= tmax_nxt;
    end
    if (sum_ready && sel_valid_r) begin
      pmin_r <= pmin_nxt;
      pmax_r <= pmax_nxt;
    end
  end

endmodule

// ----- sv/aatf_sat.sv -----
// Output stage: scale back to Q16.16, add the translation, clamp and hold the result.
module aatf_sat (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  aatf_pkg::sums_t    pmin,
  input  aatf_pkg::sums_t    pmax,
  input  aatf_pkg::coord_t   shift,
  output logic               dn_valid,
  input  logic               dn_ready,
  output aatf_pkg::box_res_t res
);
  import aatf_pkg::*;

  logic     valid_r;
  box_res_t res_r;
  box_res_t res_nxt;
  res_t     rmin [3];
  res_t     rmax [3];

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign res      = res_r;

  // Scaling, translation and clamping are all monotonic, so they apply to the extremes directly.
  always_comb begin
    res_nxt.sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      rmin[a] = RES_W'(pmin[a] >>> FRAC_SH) + RES_W'($signed(shift[a]));
      rmax[a] = RES_W'(pmax[a] >>> FRAC_SH) + RES_W'($signed(shift[a]));
      if (rmin[a] < Q16_MIN) begin
        res_nxt.mn[a] = COORD_W'(Q16_MIN);
        res_nxt.sat   = 1'b1;
      end else if (rmin[a] > Q16_MAX) begin
        res_nxt.mn[a] = COORD_W'(Q16_MAX);
      end else begin
        res_nxt.mn[a] = COORD_W'(rmin[a]);
      end
      if (rmax[a] > Q16_MAX) begin
        res_nxt.mx[a] = COORD_W'(Q16_MAX);
        res_nxt.sat   = 1'b1;
      end else if (rmax[a] < Q16_MIN) begin
        res_nxt.mx[a] = COORD_W'(Q16_MIN);
      end else begin
        res_nxt.mx[a] = COORD_W'(rmax[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule
